/* hw/rtl/slps_pkg.sv */
// Package for the sensor link poll supervisor.
// Holds the mode, status, function and register codes, the reset values of the
// configuration registers and the default counter width. No dependencies.
package slps_pkg;

  // Default width of the wrapping tick, prescale and periodic-reset counters.
  localparam int SLPS_COUNTER_BITS = 16;

  // Link modes.
  localparam logic [2:0] MODE_DISABLED = 3'd0;
  localparam logic [2:0] MODE_INACTIVE = 3'd1;
  localparam logic [2:0] MODE_WAIT     = 3'd2;
  localparam logic [2:0] MODE_READ     = 3'd3;
  localparam logic [2:0] MODE_DEINIT   = 3'd4;
  localparam logic [2:0] MODE_RECOVER  = 3'd5;

  // Link status codes.
  localparam logic [1:0] ST_READY   = 2'd0;
  localparam logic [1:0] ST_RX_WAIT = 2'd1;
  localparam logic [1:0] ST_RX_DONE = 2'd2;

  // Request kinds carried on the input tuser.
  localparam logic [1:0] FUNC_TICK    = 2'd0;
  localparam logic [1:0] FUNC_RX_DONE = 2'd1;
  localparam logic [1:0] FUNC_ENABLE  = 2'd2;
  localparam logic [1:0] FUNC_NOP     = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_LINE_THRESHOLD = 3'd0;
  localparam logic [2:0] REG_USE_READY_LINE = 3'd1;
  localparam logic [2:0] REG_POLL_PERIOD    = 3'd2;
  localparam logic [2:0] REG_READ_PRESCALE  = 3'd3;
  localparam logic [2:0] REG_DEINIT_PERIOD  = 3'd4;
  localparam logic [2:0] REG_RESET_PERIOD   = 3'd5;

  // Configuration reset values.
  localparam logic [11:0] RST_LINE_THRESHOLD = 12'd2048;
  localparam logic        RST_USE_READY_LINE = 1'b1;
  localparam logic [15:0] RST_POLL_PERIOD    = 16'd200;
  localparam logic [13:0] RST_READ_PRESCALE  = 14'd10;
  localparam logic [14:0] RST_DEINIT_PERIOD  = 15'd10;
  localparam logic [15:0] RST_RESET_PERIOD   = 16'd60000;

  // Read timeout is this many read prescale intervals.
  localparam int TIMEOUT_FACTOR = 5;

endpackage

/* hw/rtl/sensor_link_poll_supervisor.sv */
// Sensor link poll supervisor: top level with input register, state update
// and result register. Depends on slps_pkg.
//
// Takes one request per clock while the result stream is not stalled: a 1 ms tick
// with the sampled ready-line level, a receive-complete event, a new enable setting
// or a no-op (tuser selects which). Each request yields exactly one result, by way of
// the input register and the result register, holding the link mode, the
// read/bus-disable/bus-init/capture strobes, the link status and the data-available
// flag. The throughput is one request per cycle unless m_tready stalls; the only loop
// is the update of the mode and counter registers between the input register and the
// result register. Counters are COUNTER_BITS wide and wrap. Configuration registers
// may be written through the cfg port at any time but should change only while no
// request is in flight; cfg_ready is always high and indexes beyond the list are ignored.
module sensor_link_poll_supervisor
  import slps_pkg::*;
#(
  parameter int COUNTER_BITS = SLPS_COUNTER_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // Request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [11:0] line_level, [19:12] enable_value, [23:20] zero
  input  logic [1:0]  s_tuser,   // [1:0] func
  // Result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [2:0] link_state, [3] read_request, [4] bus_disable,
                                 // [5] bus_init, [6] capture_packet, [8:7] link_status,
                                 // [9] data_available, [15:10] zero
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // Compare width: wide enough for the counters and for five read prescales.
  localparam int CMP_W = (COUNTER_BITS > 17) ? COUNTER_BITS : 17;

  typedef logic [COUNTER_BITS-1:0] cnt_t;
  typedef logic [CMP_W-1:0]        cmp_t;

  // Configuration registers.
  logic [11:0] line_threshold;
  logic        use_ready_line;
  logic [15:0] poll_period;
  logic [13:0] read_prescale;
  logic [14:0] deinit_period;
  logic [15:0] reset_period;

  // Input register.
  logic        in_valid;
  logic [1:0]  in_func;
  logic [11:0] in_level;
  logic [7:0]  in_enable;

  // Supervisor state.
  logic [2:0]  mode, mode_next;
  cnt_t        tick_timer, tick_timer_next;
  cnt_t        prescale_count, prescale_count_next;
  cnt_t        reset_count, reset_count_next;
  logic        ready_flag, ready_flag_next;
  logic        enable_flag, enable_flag_next;
  logic [1:0]  status_code, status_code_next;

  // Result register fields.
  logic [2:0]  out_state;
  logic        out_read, out_disable, out_init, out_capture;
  logic [1:0]  out_status;
  logic        out_avail;

  // Combinational strobes and helpers.
  logic        read_now, disable_now, init_now, capture_now;
  logic        advance;
  cnt_t        tt;
  cnt_t        pc_inc;
  cmp_t        timeout_limit;
  cmp_t        recover_limit;

  // Handshakes: the input register moves on when the result register is free.
  assign advance   = in_valid && (!m_tvalid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_threshold <= RST_LINE_THRESHOLD;
      use_ready_line <= RST_USE_READY_LINE;
      poll_period    <= RST_POLL_PERIOD;
      read_prescale  <= RST_READ_PRESCALE;
      deinit_period  <= RST_DEINIT_PERIOD;
      reset_period   <= RST_RESET_PERIOD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_THRESHOLD: line_threshold <= cfg_data[11:0];
        REG_USE_READY_LINE: use_ready_line <= cfg_data[0];
        REG_POLL_PERIOD:    poll_period    <= cfg_data;
        REG_READ_PRESCALE:  read_prescale  <= cfg_data[13:0];
        REG_DEINIT_PERIOD:  deinit_period  <= cfg_data[14:0];
        REG_RESET_PERIOD:   reset_period   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_func   <= s_tuser;
      in_level  <= s_tdata[11:0];
      in_enable <= s_tdata[19:12];
    end
  end

  // Limits used by the read timeout and the recovery window.
  assign timeout_limit = (CMP_W'(read_prescale) << 2) + CMP_W'(read_prescale);
  assign recover_limit = CMP_W'(deinit_period) << 1;
  assign pc_inc        = prescale_count + cnt_t'(1);

  // Next-state logic for one request.
  always_comb begin
    mode_next           = mode;
    tt                  = tick_timer;
    prescale_count_next = prescale_count;
    reset_count_next    = reset_count;
    ready_flag_next     = ready_flag;
    enable_flag_next    = enable_flag;
    status_code_next    = status_code;
    read_now            = 1'b0;
    disable_now         = 1'b0;
    init_now            = 1'b0;
    capture_now         = 1'b0;

    case (in_func)
      FUNC_TICK: begin
        // Ready flag is sampled first, then the mode machine runs.
        ready_flag_next = use_ready_line ? (in_level > line_threshold) : 1'b1;
        unique case (mode)
          MODE_DISABLED: begin
            if (enable_flag) begin
              mode_next = MODE_INACTIVE;
              tt        = '0;
            end
          end
          MODE_INACTIVE: begin
            if (!enable_flag) begin
              mode_next = MODE_DISABLED;
            end else if (ready_flag_next) begin
              mode_next = MODE_WAIT;
              tt        = '0;
            end
          end
          MODE_WAIT: begin
            if (CMP_W'(reset_count) > CMP_W'(reset_period)) begin
              mode_next        = MODE_DEINIT;
              tt               = '0;
              reset_count_next = '0;
            end else if (!enable_flag) begin
              mode_next = MODE_DISABLED;
            end else begin
              // Polling continues in the same tick even when the line drops.
              if (!ready_flag_next) begin
                mode_next = MODE_INACTIVE;
              end
              if (CMP_W'(tick_timer) > CMP_W'(poll_period)) begin
                tt = '0;
              end
              read_now         = (tt == '0);
              reset_count_next = reset_count + cnt_t'(1);
            end
          end
          MODE_READ: begin
            if (!enable_flag) begin
              tt        = '0;
              mode_next = MODE_DISABLED;
            end else if (ready_flag_next) begin
              if (prescale_count == '0) begin
                read_now         = 1'b1;
                status_code_next = ST_RX_WAIT;
              end
              if (CMP_W'(tick_timer) > timeout_limit) begin
                mode_next        = MODE_DEINIT;
                tt               = '0;
                status_code_next = ST_READY;
              end
              prescale_count_next =
                (CMP_W'(pc_inc) >= CMP_W'(read_prescale)) ? '0 : pc_inc;
            end else begin
              tt               = '0;
              mode_next        = MODE_INACTIVE;
              status_code_next = ST_READY;
            end
          end
          MODE_DEINIT: begin
            if (CMP_W'(tick_timer) >= CMP_W'(deinit_period)) begin
              tt          = '0;
              disable_now = 1'b1;
              mode_next   = MODE_RECOVER;
            end
          end
          MODE_RECOVER: begin
            if (CMP_W'(tick_timer) == CMP_W'(deinit_period)) begin
              init_now = 1'b1;
            end else if (CMP_W'(tick_timer) >= recover_limit) begin
              tt        = '0;
              mode_next = MODE_WAIT;
            end
          end
          default: ;
        endcase
        tt = tt + cnt_t'(1);
      end
      FUNC_RX_DONE: begin
        if (mode == MODE_WAIT) begin
          mode_next = MODE_READ;
        end else if (mode == MODE_READ) begin
          capture_now      = 1'b1;
          status_code_next = ST_RX_DONE;
          tt               = '0;
        end
      end
      FUNC_ENABLE: begin
        if (in_enable <= 8'd1) begin
          enable_flag_next = in_enable[0];
        end
      end
      default: ;
    endcase
    tick_timer_next = tt;
  end

  // State and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= MODE_DISABLED;
      tick_timer     <= '0;
      prescale_count <= '0;
      reset_count    <= '0;
      ready_flag     <= 1'b0;
      enable_flag    <= 1'b1;
      status_code    <= ST_READY;
      m_tvalid       <= 1'b0;
    end else begin
      if (advance) begin
        mode           <= mode_next;
        tick_timer     <= tick_timer_next;
        prescale_count <= prescale_count_next;
        reset_count    <= reset_count_next;
        ready_flag     <= ready_flag_next;
        enable_flag    <= enable_flag_next;
        status_code    <= status_code_next;
        m_tvalid       <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      out_state   <= mode_next;
      out_read    <= read_now;
      out_disable <= disable_now;
      out_init    <= init_now;
      out_capture <= capture_now;
      out_status  <= status_code_next;
      out_avail   <= ready_flag_next && enable_flag_next && (mode_next == MODE_READ);
    end
  end

  assign m_tdata = {6'd0, out_avail, out_status, out_capture, out_init, out_disable,
                    out_read, out_state};

  // A processed request always leaves a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    advance |=> m_tvalid)
    else $error("result register not loaded after a request was processed");

  // At most one strobe fires per result.
  a_strobes_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0({out_read, out_disable, out_init, out_capture}))
    else $error("more than one strobe in one result");

  // Bus disable and re-init only come out of the recovery path.
  a_bus_strobes_recover: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (out_disable || out_init)) |-> (out_state == MODE_RECOVER))
    else $error("bus strobe outside recovery");

  // Data is only reported available in the read mode.
  a_avail_in_read: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_avail) |-> (out_state == MODE_READ))
    else $error("data available outside read mode");

endmodule

/* tb/sensor_link_poll_supervisor_test.sv */
// Self-checking testbench for the sensor link poll supervisor.
// Predicts every link report from its own model of the mode machine and counters.
// Depends on slps_pkg and the sensor_link_poll_supervisor RTL.
module sensor_link_poll_supervisor_test;
  timeunit 1ns;
  timeprecision 1ps;
  import slps_pkg::*;

  localparam int RECOVER_FACTOR = 2;
  localparam int IDLE_PERCENT   = 26;
  localparam int REG_COUNT      = 6;
  localparam int DRAIN_CYCLES   = 6;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_REQUESTS = 200;

  // One link report, packed as on m_tdata[9:0].
  typedef struct packed {
    logic       data_available;
    logic [1:0] link_status;
    logic       capture_packet;
    logic       bus_init;
    logic       bus_disable;
    logic       read_request;
    logic [2:0] link_state;
  } link_result_t;

  // Register settings of the supervisor.
  typedef struct packed {
    logic [11:0] threshold;
    logic        use_line;
    logic [15:0] poll;
    logic [13:0] prescale;
    logic [14:0] deinit;
    logic [15:0] reset_period;
  } link_settings_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = FUNC_TICK;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_LINE_THRESHOLD;
  logic [15:0] cfg_data = '0;

  int idle_pct = IDLE_PERCENT;
  int mismatch_count = 0;
  int cycle_count = 0;

  // Reports predicted for accepted requests, oldest first.
  link_result_t link_reports_due[$];

  // Predicted supervisor state, starting from its reset values.
  link_settings_t link_cfg = '{threshold: RST_LINE_THRESHOLD, use_line: RST_USE_READY_LINE,
                               poll: RST_POLL_PERIOD, prescale: RST_READ_PRESCALE,
                               deinit: RST_DEINIT_PERIOD, reset_period: RST_RESET_PERIOD};
  logic [2:0]  link_mode = MODE_DISABLED;
  logic [15:0] tick_count = '0;
  logic [15:0] prescale_ticks = '0;
  logic [15:0] wait_ticks = '0;
  logic        line_ready = 1'b0;
  logic        link_enabled = 1'b1;
  logic [1:0]  link_status_code = ST_READY;

  sensor_link_poll_supervisor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Advance the predicted supervisor by one request and return its report.
  function automatic link_result_t advance_supervisor(logic [1:0] fn, logic [11:0] lvl,
                                                      logic [7:0] ev);
    link_result_t r;
    int unsigned  read_timeout;
    int unsigned  recover_limit;
    r = '0;
    // Both products are taken at 32 bits so they never wrap.
    read_timeout = 32'(link_cfg.prescale) * TIMEOUT_FACTOR;
    recover_limit = 32'(link_cfg.deinit) * RECOVER_FACTOR;
    case (fn)
      FUNC_TICK: begin
        line_ready = link_cfg.use_line ? (lvl > link_cfg.threshold) : 1'b1;
        case (link_mode)
          MODE_DISABLED: begin
            if (link_enabled) begin
              link_mode = MODE_INACTIVE;
              tick_count = '0;
            end
          end
          MODE_INACTIVE: begin
            if (!link_enabled) begin
              link_mode = MODE_DISABLED;
            end else if (line_ready) begin
              link_mode = MODE_WAIT;
              tick_count = '0;
            end
          end
          MODE_WAIT: begin
            if (wait_ticks > link_cfg.reset_period) begin
              link_mode = MODE_DEINIT;
              tick_count = '0;
              wait_ticks = '0;
            end else if (!link_enabled) begin
              link_mode = MODE_DISABLED;
            end else begin
              // Losing the line still lets this tick poll and count.
              if (!line_ready) link_mode = MODE_INACTIVE;
              if (tick_count > link_cfg.poll) tick_count = '0;
              if (tick_count == '0) r.read_request = 1'b1;
              wait_ticks = wait_ticks + 16'd1;
            end
          end
          MODE_READ: begin
            if (!link_enabled) begin
              tick_count = '0;
              link_mode = MODE_DISABLED;
            end else if (line_ready) begin
              if (prescale_ticks == '0) begin
                r.read_request = 1'b1;
                link_status_code = ST_RX_WAIT;
              end
              if (32'(tick_count) > read_timeout) begin
                link_mode = MODE_DEINIT;
                tick_count = '0;
                link_status_code = ST_READY;
              end
              prescale_ticks = prescale_ticks + 16'd1;
              if (prescale_ticks >= 16'(link_cfg.prescale)) prescale_ticks = '0;
            end else begin
              tick_count = '0;
              link_mode = MODE_INACTIVE;
              link_status_code = ST_READY;
            end
          end
          MODE_DEINIT: begin
            if (tick_count >= 16'(link_cfg.deinit)) begin
              tick_count = '0;
              r.bus_disable = 1'b1;
              link_mode = MODE_RECOVER;
            end
          end
          MODE_RECOVER: begin
            if (tick_count == 16'(link_cfg.deinit)) begin
              r.bus_init = 1'b1;
            end else if (32'(tick_count) >= recover_limit) begin
              tick_count = '0;
              link_mode = MODE_WAIT;
            end
          end
          default: begin
          end
        endcase
        tick_count = tick_count + 16'd1;
      end
      FUNC_RX_DONE: begin
        if (link_mode == MODE_WAIT) begin
          link_mode = MODE_READ;
        end else if (link_mode == MODE_READ) begin
          r.capture_packet = 1'b1;
          link_status_code = ST_RX_DONE;
          tick_count = '0;
        end
      end
      FUNC_ENABLE: begin
        // Values above one leave the enable as it is.
        if (ev <= 8'd1) link_enabled = ev[0];
      end
      default: begin
      end
    endcase
    r.link_state = link_mode;
    r.link_status = link_status_code;
    r.data_available = line_ready && link_enabled && (link_mode == MODE_READ);
    return r;
  endfunction

  // Send one request, idling at random before it, and record its report.
  task automatic send_request(logic [1:0] fn, logic [11:0] lvl, logic [7:0] ev);
    logic accepted;
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= fn;
    s_tdata <= {4'b0000, ev, lvl};
    do begin
      @(negedge clk);
      accepted = s_tready;
      @(posedge clk);
    end while (!accepted);
    link_reports_due.push_back(advance_supervisor(fn, lvl, ev));
  endtask

  // Hold off new requests until every predicted report has come back.
  task automatic wait_for_reports();
    s_tvalid <= 1'b0;
    while (link_reports_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all six registers back to back; the block must be idle.
  task automatic apply_settings(link_settings_t s);
    logic [15:0] values [REG_COUNT];
    logic        accepted;
    values[REG_LINE_THRESHOLD] = 16'(s.threshold);
    values[REG_USE_READY_LINE] = 16'(s.use_line);
    values[REG_POLL_PERIOD]    = s.poll;
    values[REG_READ_PRESCALE]  = 16'(s.prescale);
    values[REG_DEINIT_PERIOD]  = 16'(s.deinit);
    values[REG_RESET_PERIOD]   = s.reset_period;
    for (int i = 0; i < REG_COUNT; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data <= values[i];
      do begin
        @(negedge clk);
        accepted = cfg_ready;
        @(posedge clk);
      end while (!accepted);
    end
    cfg_valid <= 1'b0;
    link_cfg = s;
  endtask

  // Mostly a level above the threshold, so the link comes up and stays up.
  function automatic logic [11:0] line_sample();
    if (link_cfg.threshold != 12'hFFF && $urandom_range(99) < 85) begin
      return 12'($urandom_range(4095, link_cfg.threshold + 1));
    end
    return 12'($urandom_range(4095));
  endfunction

  // Bring-up, polling, one read and enable handling at reset settings.
  task automatic test_defaults_walk();
    send_request(FUNC_TICK, 12'h000, 8'h00);     // disabled to inactive
    send_request(FUNC_TICK, 12'h800, 8'hFF);     // level at threshold is not ready
    send_request(FUNC_TICK, 12'hFFF, 8'h00);     // inactive to wait
    send_request(FUNC_TICK, 12'h801, 8'h00);
    send_request(FUNC_NOP, 12'hFFF, 8'hFF);
    send_request(FUNC_RX_DONE, 12'h000, 8'h00);  // wait to read
    send_request(FUNC_TICK, 12'hFFF, 8'h00);     // read request, receive waiting
    send_request(FUNC_RX_DONE, 12'h000, 8'h00);  // packet captured
    send_request(FUNC_ENABLE, 12'h000, 8'h02);   // out-of-range enable is ignored
    send_request(FUNC_ENABLE, 12'h000, 8'h00);
    send_request(FUNC_TICK, 12'hFFF, 8'h00);     // read to disabled
    send_request(FUNC_RX_DONE, 12'hFFF, 8'h00);  // ignored while disabled
    send_request(FUNC_ENABLE, 12'h000, 8'h01);
    send_request(FUNC_TICK, 12'h000, 8'h00);
    send_request(FUNC_TICK, 12'hFFF, 8'h00);
  endtask

  // Zero periods: forced reset at once, immediate deinit, read on every tick.
  task automatic test_fast_timeouts();
    wait_for_reports();
    apply_settings('{threshold: 12'h000, use_line: 1'b1, poll: 16'h0000, prescale: 14'h0000,
                     deinit: 15'h0000, reset_period: 16'h0000});
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_RX_DONE, 12'h000, 8'h00);
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_TICK, 12'h001, 8'h00);
    send_request(FUNC_TICK, 12'h000, 8'h00);
  endtask

  // Largest settings, apart from a read prescale of 13000, with the ready line ignored.
  task automatic test_wide_settings();
    wait_for_reports();
    apply_settings('{threshold: 12'hFFF, use_line: 1'b0, poll: 16'hFFFF, prescale: 14'd13000,
                     deinit: 15'h7FFF, reset_period: 16'hFFFF});
    send_request(FUNC_TICK, 12'h000, 8'h00);
    send_request(FUNC_RX_DONE, 12'h000, 8'h00);
    send_request(FUNC_TICK, 12'h000, 8'h00);
  endtask

  // Random traffic over several settings with short periods.
  task automatic test_random_traffic();
    link_settings_t s;
    int             pick;
    logic [1:0]     fn;
    logic [7:0]     ev;
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      wait_for_reports();
      s.threshold = 12'($urandom_range(4095));
      s.use_line = ($urandom_range(4) != 0);
      s.poll = 16'($urandom_range(12));
      s.prescale = 14'($urandom_range(6));
      s.deinit = 15'($urandom_range(8));
      s.reset_period = 16'($urandom_range(60));
      apply_settings(s);
      // One phase runs with neither side idling.
      idle_pct = (phase == 2) ? 0 : IDLE_PERCENT;
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        pick = $urandom_range(99);
        ev = 8'($urandom);
        if (pick < 68) begin
          fn = FUNC_TICK;
        end else if (pick < 84) begin
          fn = FUNC_RX_DONE;
        end else if (pick < 95) begin
          fn = FUNC_ENABLE;
          pick = $urandom_range(9);
          if (pick < 7) ev = 8'h01;
          else if (pick < 9) ev = 8'h00;
        end else begin
          fn = FUNC_NOP;
        end
        send_request(fn, line_sample(), ev);
        if ($urandom_range(199) == 0) wait_for_reports();
      end
    end
    idle_pct = IDLE_PERCENT;
  endtask

  // Compare one field of a report.
  function automatic void check_field(string name, int unsigned want, int unsigned seen);
    if (want != seen) begin
      $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, name, want, seen);
      mismatch_count++;
    end
  endfunction

  // Compare a returned report with the oldest prediction.
  task automatic check_report(logic [15:0] word);
    link_result_t want;
    link_result_t seen;
    if (link_reports_due.size() == 0) begin
      $display("%0t ns: report with none expected: expected nothing, actual %h", $time, word);
      mismatch_count++;
    end else begin
      want = link_reports_due.pop_front();
      seen = link_result_t'(word[9:0]);
      check_field("link_state", want.link_state, seen.link_state);
      check_field("read_request", want.read_request, seen.read_request);
      check_field("bus_disable", want.bus_disable, seen.bus_disable);
      check_field("bus_init", want.bus_init, seen.bus_init);
      check_field("capture_packet", want.capture_packet, seen.capture_packet);
      check_field("link_status", want.link_status, seen.link_status);
      check_field("data_available", want.data_available, seen.data_available);
      check_field("tdata padding", 0, word[15:10]);
    end
  endtask

  // Receiver stalls at random.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= idle_pct);
  end

  // Outputs are sampled mid-cycle, where they hold their value for the next edge.
  always begin
    logic       got_one;
    logic [15:0] word;
    @(negedge clk);
    got_one = !rst && m_tvalid && m_tready;
    word = m_tdata;
    @(posedge clk);
    if (got_one) check_report(word);
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("sensor_link_poll_supervisor regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_defaults_walk();
    test_fast_timeouts();
    test_wide_settings();
    test_random_traffic();
    wait_for_reports();
    if (mismatch_count == 0) begin
      $display("sensor_link_poll_supervisor regression: pass");
    end else begin
      $display("sensor_link_poll_supervisor regression: fail");
    end
    $finish;
  end

endmodule
